// ----- hw/rtl/histogram_bin_statistics_core_assert.svh -----
// assertion macros for the histogram statistics core
`ifndef HISTOGRAM_BIN_STATISTICS_CORE_ASSERT_SVH
`define HISTOGRAM_BIN_STATISTICS_CORE_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define HBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds, consequent in the next cycle
`define HBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/hbs_pkg.sv -----
`timescale 1ns / 1ps

package hbs_pkg;

    localparam int COUNT_W          = 31;
    localparam int CFG_W            = 9;
    localparam int MODE_W           = 3;
    localparam int STAT_W           = 16;
    localparam int MAX_BINS_DEFAULT = 256;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [CFG_W-1:0]   BINS_RESET = 9'd256;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STATS = 3'd4;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] mean;
        logic [STAT_W-1:0] std;
    } stat_res_t;

endpackage

// ----- hw/rtl/hbs_ram.sv -----
`timescale 1ns / 1ps

module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/hbs_stats_math.sv -----
`timescale 1ns / 1ps

module hbs_stats_math #(
    parameter int MAX_BINS = hbs_pkg::MAX_BINS_DEFAULT
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                start,
    input  logic [hbs_pkg::COUNT_W+$clog2(MAX_BINS)-1:0]        sum0,
    input  logic [hbs_pkg::COUNT_W+2*$clog2(MAX_BINS)-1:0]      sum1,
    input  logic [hbs_pkg::COUNT_W+3*$clog2(MAX_BINS)-1:0]      sum2,
    output hbs_pkg::stat_res_t                                  res
);

    localparam int IDXW = $clog2(MAX_BINS);
    localparam int CW   = hbs_pkg::COUNT_W;
    localparam int S0W  = CW + IDXW;
    localparam int S1W  = CW + 2 * IDXW;
    localparam int S2W  = CW + 3 * IDXW;
    localparam int PW   = S0W + S2W;
    localparam int NW   = PW + 16;
    localparam int DW   = 2 * S0W;
    localparam int CNTW = $clog2(NW + 1);

    typedef enum logic [2:0] {M_IDLE, M_MUL, M_DIV, M_SQRT} mstate_t;
    typedef enum logic [1:0] {MUL_VAR, MUL_SQ, MUL_DEN} mstep_t;

    mstate_t          state_reg;
    mstep_t           mstep_reg;
    logic [S1W-1:0]   ma_reg;
    logic [PW-1:0]    mb_reg;
    logic [PW-1:0]    acc_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    sq_reg;
    logic [DW-1:0]    den_reg;
    logic [NW-1:0]    dn_reg;
    logic [DW-1:0]    rr_reg;
    logic [32:0]      q_reg;
    logic             ovf_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             div_mean_reg;
    logic [31:0]      var_reg;
    logic [31:0]      sv_reg;
    logic [31:0]      root_reg;
    logic [31:0]      bit_reg;
    logic [15:0]      mean_reg;
    logic [15:0]      std_reg;
    logic             done_reg;

    logic [PW-1:0]    acc_add;
    logic [PW-1:0]    diff;
    logic [DW:0]      r_sh;
    logic             r_ge;
    logic [DW:0]      r_sub;
    logic [32:0]      tb;
    logic             sq_ge;
    logic             q_sat;

    assign acc_add = acc_reg + (ma_reg[0] ? mb_reg : '0);
    assign diff    = (p_reg >= sq_reg) ? (p_reg - sq_reg) : '0;
    assign r_sh    = {rr_reg, dn_reg[NW-1]};
    assign r_ge    = r_sh >= {1'b0, den_reg};
    assign r_sub   = r_sh - {1'b0, den_reg};
    assign tb      = {1'b0, root_reg} + {1'b0, bit_reg};
    assign sq_ge   = {1'b0, sv_reg} >= tb;
    assign q_sat   = ovf_reg | q_reg[32];

    assign res.done = done_reg;
    assign res.mean = mean_reg;
    assign res.std  = std_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        if (sum0 == '0)
                        begin
                            mean_reg <= '0;
                            std_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            ma_reg    <= S1W'(sum0);
                            mb_reg    <= PW'(sum2);
                            acc_reg   <= '0;
                            mstep_reg <= MUL_VAR;
                            state_reg <= M_MUL;
                        end
                    end
                end
                M_MUL:
                begin
                    if (ma_reg == '0)
                    begin
                        acc_reg <= '0;
                        case (mstep_reg)
                            MUL_VAR:
                            begin
                                p_reg     <= acc_reg;
                                ma_reg    <= sum1;
                                mb_reg    <= PW'(sum1);
                                mstep_reg <= MUL_SQ;
                            end
                            MUL_SQ:
                            begin
                                sq_reg    <= acc_reg;
                                ma_reg    <= S1W'(sum0);
                                mb_reg    <= PW'(sum0);
                                mstep_reg <= MUL_DEN;
                            end
                            default:
                            begin
                                den_reg      <= acc_reg[DW-1:0];
                                dn_reg       <= {diff, 16'b0};
                                rr_reg       <= '0;
                                q_reg        <= '0;
                                ovf_reg      <= 1'b0;
                                cnt_reg      <= '0;
                                div_mean_reg <= 1'b0;
                                state_reg    <= M_DIV;
                            end
                        endcase
                    end
                    else
                    begin
                        acc_reg <= acc_add;
                        ma_reg  <= ma_reg >> 1;
                        mb_reg  <= mb_reg << 1;
                    end
                end
                M_DIV:
                begin
                    if (cnt_reg == CNTW'(NW))
                    begin
                        if (!div_mean_reg)
                        begin
                            var_reg      <= q_sat ? 32'hFFFF_FFFF : q_reg[31:0];
                            dn_reg       <= NW'(sum1) << 8;
                            den_reg      <= DW'(sum0);
                            rr_reg       <= '0;
                            q_reg        <= '0;
                            ovf_reg      <= 1'b0;
                            cnt_reg      <= '0;
                            div_mean_reg <= 1'b1;
                        end
                        else
                        begin
                            mean_reg  <= (q_sat || (q_reg[31:16] != '0)) ? 16'hFFFF
                                                                         : q_reg[15:0];
                            sv_reg    <= var_reg;
                            root_reg  <= '0;
                            bit_reg   <= 32'h4000_0000;
                            state_reg <= M_SQRT;
                        end
                    end
                    else
                    begin
                        rr_reg  <= r_ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
                        dn_reg  <= dn_reg << 1;
                        q_reg   <= {q_reg[31:0], r_ge};
                        ovf_reg <= ovf_reg | q_reg[32];
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                M_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        std_reg   <= root_reg[15:0];
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                    else
                    begin
                        if (sq_ge)
                        begin
                            sv_reg   <= sv_reg - tb[31:0];
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/histogram_bin_statistics_core.sv -----
// channel   | signals                                              | handshake
// ----------+------------------------------------------------------+----------------------
// request   | mode, bin_index, write_count, spike_rank             | start & !busy
// result    | bin_count, mean_index, std_dev, largest_count,       | done, one cycle
//           | spike_value                                          |
// config    | cfg_data (bins in use)                               | cfg_valid & cfg_ready
//
// write: done from idle, increment and read: one RAM read first, clear: all MAX_BINS bins
// statistics: a walk over the bins per spike rank pass (one bin memory read port), then
// multiply, divide and square root steps in hbs_stats_math
// after reset a clearing pass over all MAX_BINS bins runs with busy high
// results are shown for one cycle with done; the receiver cannot stall
`timescale 1ns / 1ps

module histogram_bin_statistics_core #(
    parameter int MAX_BINS = hbs_pkg::MAX_BINS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [hbs_pkg::MODE_W-1:0]   mode,
    input  logic [7:0]                   bin_index,
    input  logic [hbs_pkg::COUNT_W-1:0]  write_count,
    input  logic [7:0]                   spike_rank,
    output logic                         done,
    output logic [hbs_pkg::COUNT_W-1:0]  bin_count,
    output logic [hbs_pkg::STAT_W-1:0]   mean_index,
    output logic [hbs_pkg::STAT_W-1:0]   std_dev,
    output logic [hbs_pkg::COUNT_W-1:0]  largest_count,
    output logic signed [31:0]           spike_value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hbs_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IDXW = $clog2(MAX_BINS);
    localparam int NBW  = $clog2(MAX_BINS + 1);
    localparam int CW   = hbs_pkg::COUNT_W;
    localparam int S0W  = CW + IDXW;
    localparam int S1W  = CW + 2 * IDXW;
    localparam int S2W  = CW + 3 * IDXW;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_INC, S_READ, S_WALK, S_MATH} state_t;

    state_t                     state_reg;
    logic [hbs_pkg::CFG_W-1:0]  bins_reg;
    logic [NBW-1:0]             addr_cnt_reg;
    logic                       clr_reply_reg;
    logic [IDXW-1:0]            idx_reg;
    logic [7:0]                 rank_reg;
    logic [7:0]                 rcnt_reg;
    logic                       va_reg;
    logic [IDXW-1:0]            ia_reg;
    logic [2*IDXW-1:0]          i2a_reg;
    logic                       vb_reg;
    logic [CW-1:0]              cb_reg;
    logic [S0W-1:0]             p1b_reg;
    logic [S1W-1:0]             p2b_reg;
    logic [S0W-1:0]             sum0_reg;
    logic [S1W-1:0]             sum1_reg;
    logic [S2W-1:0]             sum2_reg;
    logic [CW-1:0]              largest_reg;
    logic                       pass0_reg;
    logic                       found_reg;
    logic [CW-1:0]              best_reg;
    logic [CW-1:0]              prev_reg;
    logic                       have_prev_reg;
    logic                       math_start_reg;
    logic                       done_reg;
    logic [CW-1:0]              bin_count_reg;
    logic [15:0]                mean_reg;
    logic [15:0]                std_reg;
    logic [CW-1:0]              largest_out_reg;
    logic [31:0]                spike_reg;

    logic [NBW-1:0]             nb;
    logic [IDXW-1:0]            sel_idx;
    logic                       issue;
    logic                       accept;
    logic                       ram_we;
    logic [IDXW-1:0]            ram_waddr;
    logic [CW-1:0]              ram_wdata;
    logic [IDXW-1:0]            ram_raddr;
    logic [CW-1:0]              ram_rdata;
    hbs_pkg::stat_res_t         math_res;

    assign busy          = state_reg != S_IDLE;
    assign accept        = start && !busy;
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign bin_count     = bin_count_reg;
    assign mean_index    = mean_reg;
    assign std_dev       = std_reg;
    assign largest_count = largest_out_reg;
    assign spike_value   = spike_reg;
    assign issue         = (state_reg == S_WALK) && (addr_cnt_reg < nb);

    always_comb
    begin
        if (bins_reg == '0)
        begin
            nb = NBW'(1);
        end
        else if (32'(bins_reg) > 32'(MAX_BINS))
        begin
            nb = NBW'(MAX_BINS);
        end
        else
        begin
            nb = NBW'(bins_reg);
        end
    end

    assign sel_idx = (32'(bin_index) >= 32'(nb)) ? '0 : IDXW'(bin_index);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_cnt_reg[IDXW-1:0];
        ram_wdata = '0;
        ram_raddr = sel_idx;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                if (accept && (mode == hbs_pkg::MODE_WRITE))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = sel_idx;
                    ram_wdata = write_count;
                end
            end
            S_INC:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = (ram_rdata == hbs_pkg::COUNT_MAX) ? ram_rdata
                                                              : ram_rdata + 1'b1;
            end
            S_WALK:
            begin
                ram_raddr = addr_cnt_reg[IDXW-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    hbs_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hbs_stats_math #(
        .MAX_BINS (MAX_BINS)
    ) u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .start (math_start_reg),
        .sum0  (sum0_reg),
        .sum1  (sum1_reg),
        .sum2  (sum2_reg),
        .res   (math_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            bins_reg       <= hbs_pkg::BINS_RESET;
            addr_cnt_reg   <= '0;
            clr_reply_reg  <= 1'b0;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            math_start_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg       <= 1'b0;
            math_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                bins_reg <= cfg_data;
            end

            // bin walk pipeline
            va_reg  <= issue;
            ia_reg  <= addr_cnt_reg[IDXW-1:0];
            i2a_reg <= (2*IDXW)'(addr_cnt_reg[IDXW-1:0])
                     * (2*IDXW)'(addr_cnt_reg[IDXW-1:0]);
            vb_reg  <= va_reg;
            cb_reg  <= ram_rdata;
            p1b_reg <= S0W'(ram_rdata) * S0W'(ia_reg);
            p2b_reg <= S1W'(ram_rdata) * S1W'(i2a_reg);

            case (state_reg)
                S_CLEAR:
                begin
                    addr_cnt_reg <= addr_cnt_reg + 1'b1;
                    if (addr_cnt_reg == NBW'(MAX_BINS - 1))
                    begin
                        done_reg  <= clr_reply_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg         <= sel_idx;
                        rank_reg        <= spike_rank;
                        bin_count_reg   <= '0;
                        mean_reg        <= '0;
                        std_reg         <= '0;
                        largest_out_reg <= '0;
                        spike_reg       <= '0;
                        case (mode)
                            hbs_pkg::MODE_CLEAR:
                            begin
                                addr_cnt_reg  <= '0;
                                clr_reply_reg <= 1'b1;
                                state_reg     <= S_CLEAR;
                            end
                            hbs_pkg::MODE_WRITE:
                            begin
                                done_reg <= 1'b1;
                            end
                            hbs_pkg::MODE_INC:
                            begin
                                state_reg <= S_INC;
                            end
                            hbs_pkg::MODE_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            hbs_pkg::MODE_STATS:
                            begin
                                addr_cnt_reg  <= '0;
                                sum0_reg      <= '0;
                                sum1_reg      <= '0;
                                sum2_reg      <= '0;
                                largest_reg   <= '0;
                                pass0_reg     <= 1'b1;
                                found_reg     <= 1'b0;
                                best_reg      <= '0;
                                prev_reg      <= '0;
                                have_prev_reg <= 1'b0;
                                rcnt_reg      <= '0;
                                state_reg     <= S_WALK;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_INC:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_READ:
                begin
                    bin_count_reg <= ram_rdata;
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_WALK:
                begin
                    if (issue)
                    begin
                        addr_cnt_reg <= addr_cnt_reg + 1'b1;
                    end
                    if (vb_reg)
                    begin
                        if (pass0_reg)
                        begin
                            sum0_reg <= sum0_reg + S0W'(cb_reg);
                            sum1_reg <= sum1_reg + S1W'(p1b_reg);
                            sum2_reg <= sum2_reg + S2W'(p2b_reg);
                            if (cb_reg > largest_reg)
                            begin
                                largest_reg <= cb_reg;
                            end
                        end
                        if ((!found_reg || (cb_reg > best_reg))
                            && (!have_prev_reg || (cb_reg < prev_reg)))
                        begin
                            best_reg  <= cb_reg;
                            found_reg <= 1'b1;
                        end
                    end
                    if (!issue && !va_reg && !vb_reg)
                    begin
                        pass0_reg <= 1'b0;
                        if ((rcnt_reg < rank_reg) && found_reg)
                        begin
                            prev_reg      <= best_reg;
                            have_prev_reg <= 1'b1;
                            rcnt_reg      <= rcnt_reg + 1'b1;
                            if (({1'b0, rcnt_reg} + 9'd1) < {1'b0, rank_reg})
                            begin
                                addr_cnt_reg <= '0;
                                found_reg    <= 1'b0;
                                best_reg     <= '0;
                            end
                            else
                            begin
                                math_start_reg <= 1'b1;
                                state_reg      <= S_MATH;
                            end
                        end
                        else
                        begin
                            math_start_reg <= 1'b1;
                            state_reg      <= S_MATH;
                        end
                    end
                end
                S_MATH:
                begin
                    if (math_res.done)
                    begin
                        mean_reg        <= math_res.mean;
                        std_reg         <= math_res.std;
                        largest_out_reg <= largest_reg;
                        spike_reg       <= have_prev_reg ? {1'b0, prev_reg} : '1;
                        done_reg        <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "histogram_bin_statistics_core_assert.svh"

    `HBS_ASSERT_NEXT(a_write_reply, accept && (mode == hbs_pkg::MODE_WRITE), done && !busy)
    `HBS_ASSERT_NOW(a_done_idle, done, !busy)
    `HBS_ASSERT_NEXT(a_read_busy, accept && (mode == hbs_pkg::MODE_READ), busy && !done)

endmodule
